[rtl/fmd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fmd_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int HELD_W      = RING_AW + 1;

    localparam int HEAD_BYTES  = 16;
    localparam int TRADE_BODY  = 12;
    localparam int QUOTE_BODY  = 24;
    localparam int TRAIL_BYTES = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [5:0] SIZE_TRADE = 6'(HEAD_BYTES + TRADE_BODY + TRAIL_BYTES);
    localparam logic [5:0] SIZE_QUOTE = 6'(HEAD_BYTES + QUOTE_BODY + TRAIL_BYTES);
    localparam logic [5:0] SIZE_BEAT  = 6'(HEAD_BYTES + TRAIL_BYTES);
    localparam int FRM_BYTES          = HEAD_BYTES + QUOTE_BODY;

    localparam logic [15:0] TYPE_TRADE = 16'h0001;
    localparam logic [15:0] TYPE_QUOTE = 16'h0002;
    localparam logic [15:0] TYPE_BEAT  = 16'h0003;

    localparam logic [1:0] KIND_TRADE = 2'd0;
    localparam logic [1:0] KIND_QUOTE = 2'd1;
    localparam logic [1:0] KIND_BEAT  = 2'd2;

    localparam int OUT_DATA_W = 352;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADDR,
        S_DATA,
        S_GOOD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [7:0]  bad_checksum_count;
        logic [31:0] expected_seq;
        logic        seq_gap;
        logic [31:0] ask_quantity;
        logic [63:0] ask_price;
        logic [31:0] qty_or_bid_qty;
        logic [63:0] price_or_bid;
        logic [15:0] symbol_id;
        logic [63:0] timestamp;
        logic [31:0] sequence_res;
        logic [1:0]  msg_kind;
    } t_result;

    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic [1:0]        n_res;
        logic              busy;
    } t_status;

endpackage
`default_nettype wire

[rtl/feed_message_deframer_unit.sv]
// Feed message deframer.
// Slave channel: one raw feed byte per word on s_axis_tdata.
// Master channel: one word per good message; tdata carries the decoded
// header and body fields, tuser the message kind, tlast marks the final
// message completed by the byte just taken.
// Each byte is written into a 64-entry ring; the sequencer then rescans
// the ring through its single read port, with an address step and a
// data step per byte read. With 16 or more bytes held, it reads the
// type from the first two bytes; a known type whose frame is not yet
// all held waits for more bytes. A whole frame is walked for its
// checksum; after a bad checksum or an unknown type one byte is dropped
// and the scan starts again. Each result waits in the pending register
// while the scan goes on, then passes through the output register to
// m_axis_tvalid.
// s_axis_tready is low while a byte is being processed.
// Results go through an output register; when the receiver stalls, the
// block holds the next result and stops scanning until the register frees.
// Reset (synchronous, active low) empties the ring and clears the last
// sequence and the checksum failure tally.
`timescale 1ns / 1ps
`default_nettype none
module feed_message_deframer_unit
    import fmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // stream_byte
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // sequence_res, timestamp, symbol_id, price_or_bid, qty_or_bid_qty,
    // ask_price, ask_quantity, seq_gap, expected_seq, bad_checksum_count, pad
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    output      logic [1:0]            m_axis_tuser,  // msg_kind
    output      logic                  m_axis_tlast   // last_of_run
);
    logic    w_res_valid, w_res_last, w_res_ready;
    t_result w_res;
    t_status w_stat;
    logic    r_out_v;
    t_result r_out;
    logic    r_out_last;

    fmd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .o_byte_ready (s_axis_tready),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_res_last   (w_res_last),
        .i_res_ready  (w_res_ready),
        .o_stat       (w_stat)
    );

    assign w_res_ready = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_res_ready) begin
            r_out_v <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out      <= w_res;
            r_out_last <= w_res_last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.msg_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'd0, r_out.bad_checksum_count, r_out.expected_seq,
                            r_out.seq_gap, r_out.ask_quantity, r_out.ask_price,
                            r_out.qty_or_bid_qty, r_out.price_or_bid, r_out.symbol_id,
                            r_out.timestamp, r_out.sequence_res};

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.held <= HELD_W'(RING_DEPTH))
        else $error("ring holds more bytes than its depth");

    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.n_res <= 2'(MAX_RESULTS))
        else $error("too many results from one byte");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_stat.busy && !w_res_valid)
        else $error("byte taken while a step is in progress");

    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_stat.busy)
        else $error("result offered outside a step");
endmodule
`default_nettype wire

[rtl/fmd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/fmd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module fmd_core
    import fmd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_byte_valid,
    input  wire logic [7:0] i_byte,
    output      logic    o_byte_ready,
    output      logic    o_res_valid,
    output      t_result o_res,
    output      logic    o_res_last,
    input  wire logic    i_res_ready,
    output      t_status o_stat
);
    t_state            r_state, n_state;
    logic [RING_AW-1:0] r_rd, n_rd;
    logic [HELD_W-1:0] r_held, n_held;
    logic [31:0]       r_prev, n_prev;
    logic [7:0]        r_tally, n_tally;
    logic [1:0]        r_nres, n_nres;
    logic [5:0]        r_cnt, n_cnt;
    logic [5:0]        r_size, n_size;
    logic [1:0]        r_kind, n_kind;
    logic [7:0]        r_xor, n_xor;
    logic [31:0]       r_trl, n_trl;
    logic [7:0]        r_frm [FRM_BYTES];
    t_result           r_pend, n_pend;
    logic              r_pend_v, n_pend_v;

    logic               w_we;
    logic [RING_AW-1:0] w_waddr;
    logic [RING_AW-1:0] w_raddr;
    logic [7:0]         w_q;
    logic [15:0]        w_type;
    t_result            w_new;
    logic [31:0]        w_seq;

    fmd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_raddr = r_rd + RING_AW'(r_cnt);
    assign w_type  = {w_q, r_frm[0]};

    // fields of the captured frame; body bytes of shorter kinds read as zero
    always_comb begin
        w_seq                  = {r_frm[5], r_frm[4], r_frm[3], r_frm[2]};
        w_new.msg_kind         = r_kind;
        w_new.sequence_res     = w_seq;
        w_new.timestamp        = {r_frm[13], r_frm[12], r_frm[11], r_frm[10],
                                  r_frm[9], r_frm[8], r_frm[7], r_frm[6]};
        w_new.symbol_id        = {r_frm[15], r_frm[14]};
        w_new.price_or_bid     = '0;
        w_new.qty_or_bid_qty   = '0;
        w_new.ask_price        = '0;
        w_new.ask_quantity     = '0;
        if (r_kind != KIND_BEAT) begin
            w_new.price_or_bid   = {r_frm[23], r_frm[22], r_frm[21], r_frm[20],
                                    r_frm[19], r_frm[18], r_frm[17], r_frm[16]};
            w_new.qty_or_bid_qty = {r_frm[27], r_frm[26], r_frm[25], r_frm[24]};
        end
        if (r_kind == KIND_QUOTE) begin
            w_new.ask_price    = {r_frm[35], r_frm[34], r_frm[33], r_frm[32],
                                  r_frm[31], r_frm[30], r_frm[29], r_frm[28]};
            w_new.ask_quantity = {r_frm[39], r_frm[38], r_frm[37], r_frm[36]};
        end
        w_new.seq_gap            = (r_prev != 32'd0) && (w_seq != r_prev + 32'd1);
        w_new.expected_seq       = r_prev + 32'd1;
        w_new.bad_checksum_count = r_tally;
    end

    always_comb begin
        n_state  = r_state;
        n_rd     = r_rd;
        n_held   = r_held;
        n_prev   = r_prev;
        n_tally  = r_tally;
        n_nres   = r_nres;
        n_cnt    = r_cnt;
        n_size   = r_size;
        n_kind   = r_kind;
        n_xor    = r_xor;
        n_trl    = r_trl;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        w_we     = 1'b0;
        w_waddr  = r_rd + RING_AW'(r_held);
        o_byte_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res_last   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_byte_ready = 1'b1;
                if (i_byte_valid) begin
                    w_we   = 1'b1;
                    n_nres = 2'd0;
                    if (r_held == HELD_W'(RING_DEPTH)) begin
                        // ring full: oldest byte goes, new byte lands in its slot
                        n_rd = r_rd + 1'b1;
                    end else begin
                        n_held = r_held + 1'b1;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_held >= HELD_W'(HEAD_BYTES) && r_nres != 2'(MAX_RESULTS)) begin
                    n_cnt   = '0;
                    n_xor   = '0;
                    n_state = S_ADDR;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_ADDR: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                n_trl   = {w_q, r_trl[31:8]};
                n_state = S_ADDR;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt < 6'd2 || r_cnt < r_size - 6'(TRAIL_BYTES)) begin
                    n_xor = r_xor ^ w_q;
                end
                if (r_cnt == 6'd1) begin
                    case (w_type)
                        TYPE_TRADE: begin n_size = SIZE_TRADE; n_kind = KIND_TRADE; end
                        TYPE_QUOTE: begin n_size = SIZE_QUOTE; n_kind = KIND_QUOTE; end
                        TYPE_BEAT:  begin n_size = SIZE_BEAT;  n_kind = KIND_BEAT;  end
                        default:    begin n_size = '0; end
                    endcase
                    if (n_size == 6'd0) begin
                        n_rd    = r_rd + 1'b1;
                        n_held  = r_held - 1'b1;
                        n_state = S_CHECK;
                    end else if (r_held < HELD_W'(n_size)) begin
                        n_state = S_FINISH;
                    end
                end else if (r_cnt == r_size - 6'd1) begin
                    if (n_trl == {24'd0, r_xor}) begin
                        n_state = S_GOOD;
                    end else begin
                        if (r_tally != 8'hFF) begin
                            n_tally = r_tally + 8'd1;
                        end
                        n_rd    = r_rd + 1'b1;
                        n_held  = r_held - 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_GOOD: begin
                // a result waits in pend until we know whether another follows
                o_res_valid = r_pend_v;
                if (!r_pend_v || i_res_ready) begin
                    n_pend   = w_new;
                    n_pend_v = 1'b1;
                    n_prev   = w_seq;
                    n_tally  = '0;
                    n_rd     = r_rd + RING_AW'(r_size);
                    n_held   = r_held - HELD_W'(r_size);
                    n_nres   = r_nres + 2'd1;
                    n_state  = S_CHECK;
                end
            end
            S_FINISH: begin
                o_res_valid = r_pend_v;
                o_res_last  = 1'b1;
                if (!r_pend_v || i_res_ready) begin
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res       = r_pend;
    assign o_stat.held = r_held;
    assign o_stat.n_res = r_nres;
    assign o_stat.busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd     <= '0;
            r_held   <= '0;
            r_prev   <= '0;
            r_tally  <= '0;
            r_nres   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd     <= n_rd;
            r_held   <= n_held;
            r_prev   <= n_prev;
            r_tally  <= n_tally;
            r_nres   <= n_nres;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_size <= n_size;
        r_kind <= n_kind;
        r_xor  <= n_xor;
        r_trl  <= n_trl;
        r_pend <= n_pend;
        if (r_state == S_DATA && r_cnt < 6'(FRM_BYTES)) begin
            r_frm[r_cnt] <= w_q;
        end
    end
endmodule
`default_nettype wire

[verif/tb_feed_message_deframer_unit.sv]
`timescale 1ns / 1ps
module tb_feed_message_deframer_unit;
    import fmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        t_result r;
        bit      last;
    } t_expect;

    // scoreboard: runs the deframing rules on each accepted byte, checks each message
    class frame_scoreboard;
        bit [7:0]    ring[RING_DEPTH];
        int          rd_ptr;
        int          held;
        bit [31:0]   prev_seq;
        int          fail_tally;
        t_expect     pending_msgs[$];
        int          errors;
        int          msgs_checked;
        int          bytes_taken;
        int          gaps_seen;
        int          kinds_seen[3];

        function new();
            rd_ptr = 0;
            held = 0;
            prev_seq = '0;
            fail_tally = 0;
            errors = 0;
            msgs_checked = 0;
            bytes_taken = 0;
            gaps_seen = 0;
        endfunction

        function bit [7:0] peek(int k);
            return ring[(rd_ptr + k) % RING_DEPTH];
        endfunction

        function bit [63:0] peek_le(int k, int n);
            bit [63:0] v;
            v = '0;
            for (int i = 0; i < n; i++) v |= 64'(peek(k + i)) << (8 * i);
            return v;
        endfunction

        function void drop(int n);
            rd_ptr = (rd_ptr + n) % RING_DEPTH;
            held -= n;
        endfunction

        function void note_byte(bit [7:0] b);
            int          n;
            bit [15:0]   typ;
            int          size;
            bit [1:0]    kind;
            bit [7:0]    sum;
            bit [31:0]   seq;
            t_expect     e;
            bytes_taken++;
            if (held >= RING_DEPTH) drop(1);
            ring[(rd_ptr + held) % RING_DEPTH] = b;
            held++;
            n = 0;
            while (held >= HEAD_BYTES && n < MAX_RESULTS) begin
                typ = 16'(peek_le(0, 2));
                if (typ == TYPE_TRADE) begin
                    size = int'(SIZE_TRADE);
                    kind = KIND_TRADE;
                end else if (typ == TYPE_QUOTE) begin
                    size = int'(SIZE_QUOTE);
                    kind = KIND_QUOTE;
                end else if (typ == TYPE_BEAT) begin
                    size = int'(SIZE_BEAT);
                    kind = KIND_BEAT;
                end else begin
                    drop(1);
                    continue;
                end
                if (held < size) break;
                sum = '0;
                for (int i = 0; i < size - TRAIL_BYTES; i++) sum ^= peek(i);
                if (peek_le(size - TRAIL_BYTES, 4) != 64'(sum)) begin
                    if (fail_tally < 255) fail_tally++;
                    drop(1);
                    continue;
                end
                seq = 32'(peek_le(2, 4));
                e.r = '0;
                e.r.msg_kind = kind;
                e.r.sequence_res = seq;
                e.r.timestamp = peek_le(6, 8);
                e.r.symbol_id = 16'(peek_le(14, 2));
                if (kind != KIND_BEAT) begin
                    e.r.price_or_bid = peek_le(16, 8);
                    e.r.qty_or_bid_qty = 32'(peek_le(24, 4));
                end
                if (kind == KIND_QUOTE) begin
                    e.r.ask_price = peek_le(28, 8);
                    e.r.ask_quantity = 32'(peek_le(36, 4));
                end
                e.r.seq_gap = (prev_seq != 0) && (seq != prev_seq + 32'd1);
                e.r.expected_seq = prev_seq + 32'd1;
                e.r.bad_checksum_count = 8'(fail_tally);
                e.last = 1'b0;
                pending_msgs.push_back(e);
                prev_seq = seq;
                fail_tally = 0;
                drop(size);
                n++;
            end
            if (n > 0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
        endfunction

        task report(string what, bit [63:0] got, bit [63:0] want);
            errors++;
            $display("[%0t] mismatch on message %0d: %s got %h want %h",
                     $realtime, msgs_checked, what, got, want);
        endtask

        task cmp(string what, bit [63:0] got, bit [63:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_msg(logic [OUT_DATA_W-1:0] d, logic [1:0] user, logic last);
            t_expect e;
            if (pending_msgs.size() == 0) begin
                report("unexpected message, seq", 64'(d[31:0]), '0);
                return;
            end
            e = pending_msgs.pop_front();
            cmp("msg_kind", 64'(user), 64'(e.r.msg_kind));
            cmp("sequence_res", 64'(d[31:0]), 64'(e.r.sequence_res));
            cmp("timestamp", d[95:32], e.r.timestamp);
            cmp("symbol_id", 64'(d[111:96]), 64'(e.r.symbol_id));
            cmp("price_or_bid", d[175:112], e.r.price_or_bid);
            cmp("qty_or_bid_qty", 64'(d[207:176]), 64'(e.r.qty_or_bid_qty));
            cmp("ask_price", d[271:208], e.r.ask_price);
            cmp("ask_quantity", 64'(d[303:272]), 64'(e.r.ask_quantity));
            cmp("seq_gap", 64'(d[304]), 64'(e.r.seq_gap));
            cmp("expected_seq", 64'(d[336:305]), 64'(e.r.expected_seq));
            cmp("bad_checksum_count", 64'(d[344:337]), 64'(e.r.bad_checksum_count));
            cmp("last_of_run", 64'(last), 64'(e.last));
            if (e.r.seq_gap) gaps_seen++;
            kinds_seen[e.r.msg_kind]++;
            msgs_checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    frame_scoreboard sb;
    bit              src_idle_on;
    bit              snk_idle_on;
    bit              hold_req;
    int              cycles;
    bit [31:0]       next_seq;

    feed_message_deframer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_msg(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task send_byte(input bit [7:0] b);
        if (src_idle_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    // fill: 0 random, 1 zeros, 2 ones; fault: 0 good, 1 bad xor, 2 upper trailer bits
    task send_frame(input bit [15:0] typ, input bit [31:0] seq, input int fill,
                    input int fault);
        bit [7:0]  fr[$];
        bit [7:0]  sum;
        bit [31:0] trail;
        int        size;
        size = (typ == TYPE_TRADE) ? int'(SIZE_TRADE) :
               (typ == TYPE_QUOTE) ? int'(SIZE_QUOTE) : int'(SIZE_BEAT);
        fr.push_back(typ[7:0]);
        fr.push_back(typ[15:8]);
        for (int i = 0; i < 4; i++) fr.push_back(seq[8*i +: 8]);
        for (int i = 6; i < size - TRAIL_BYTES; i++)
            fr.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom));
        sum = '0;
        foreach (fr[i]) sum ^= fr[i];
        trail = {24'h0, sum};
        if (fault == 1) trail[7:0] = sum ^ 8'(1 << $urandom_range(0, 7));
        if (fault == 2) trail[31:8] = 24'(1 << $urandom_range(0, 23));
        for (int i = 0; i < 4; i++) fr.push_back(trail[8*i +: 8]);
        foreach (fr[i]) send_byte(fr[i]);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_msgs.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task random_item();
        int        pick;
        bit [15:0] typ;
        pick = $urandom_range(0, 99);
        typ = 16'($urandom_range(1, 3));
        if (pick < 78) begin
            if ($urandom_range(0, 9) == 0) next_seq = $urandom;
            send_frame(typ, next_seq, 0, 0);
            next_seq++;
        end else if (pick < 86) begin
            send_frame(typ, next_seq, 0, 1);
        end else if (pick < 90) begin
            send_frame(typ, next_seq, 0, 2);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        hold_req = 1'b0;
        cycles = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: each kind, field extremes, sequence wrap and zero, faults
        send_frame(TYPE_TRADE, 32'd1, 0, 0);
        send_frame(TYPE_QUOTE, 32'd2, 2, 0);
        send_frame(TYPE_BEAT, 32'hFFFF_FFFF, 1, 0);
        send_frame(TYPE_BEAT, 32'h0000_0000, 2, 0);
        send_frame(TYPE_BEAT, 32'd77, 1, 0);       // last seq zero: no gap check
        send_frame(TYPE_BEAT, 32'd78, 0, 1);
        send_frame(TYPE_BEAT, 32'd78, 0, 2);
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);
        send_frame(TYPE_BEAT, 32'd78, 0, 0);
        drain();
        next_seq = 32'd79;

        while (sb.bytes_taken < 215) random_item();

        // no idling from here; receiver holds off while frames keep coming
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 3; i++) begin
            send_frame(TYPE_BEAT, next_seq, 0, 0);
            next_seq++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_msgs.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);

        $display("covered %0d bytes, %0d messages (trade %0d, quote %0d, heartbeat %0d)",
                 sb.bytes_taken, sb.msgs_checked, sb.kinds_seen[0], sb.kinds_seen[1],
                 sb.kinds_seen[2]);
        $display("with %0d sequence gaps, checksum faults, noise and a long receiver stall",
                 sb.gaps_seen);
        if (sb.errors == 0 && sb.pending_msgs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
